@@ src/ptr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptr_pkg
// Shared types, codes and pixel arithmetic for the phosphor trace renderer.
// ----------------------------------------------------------------------------
package ptr_pkg;

  // default frame geometry
  localparam int FRAME_WIDTH_DEF  = 1024;
  localparam int FRAME_HEIGHT_DEF = 512;

  // width used to compare port values against frame limits (holds 4096)
  localparam int CMP_W = 13;

  localparam int PIXEL_W = 24;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  // item operation codes
  localparam logic [1:0] OP_TRACE = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // colour channel codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_INC_STEP = 1'd0;
  localparam logic [0:0] CFG_DEC_STEP = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_SCAN_WR
  } state_t;

  // scan result handed from the engine to the output register
  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] pixel;
  } res_t;

  function automatic logic [7:0] sat_add8(input logic [7:0] v, input logic [7:0] a);
    logic [8:0] s;
    s = {1'b0, v} + {1'b0, a};
    return s[8] ? BYTE_MAX : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub8(input logic [7:0] v, input logic [7:0] a);
    return (v > a) ? (v - a) : 8'd0;
  endfunction

  // brighten one colour byte of a pixel
  function automatic logic [PIXEL_W-1:0] hit_pixel(input logic [PIXEL_W-1:0] px,
                                                   input logic [1:0] ch,
                                                   input logic [7:0] inc);
    logic [PIXEL_W-1:0] r;
    r = px;
    case (ch)
      CH_BLUE:  r[7:0]   = sat_add8(px[7:0], inc);
      CH_GREEN: r[15:8]  = sat_add8(px[15:8], inc);
      CH_RED:   r[23:16] = sat_add8(px[23:16], inc);
      default:  r = px;
    endcase
    return r;
  endfunction

  // fade green and red, blue untouched
  function automatic logic [PIXEL_W-1:0] decay_pixel(input logic [PIXEL_W-1:0] px,
                                                     input logic [7:0] dec);
    return {sat_sub8(px[23:16], dec), sat_sub8(px[15:8], dec), px[7:0]};
  endfunction

endpackage
`default_nettype wire

@@ src/ptr_frame_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptr_frame_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptr_frame_mem #(
  parameter int ADDR_W = 19
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [ptr_pkg::PIXEL_W-1:0] rd_data,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [ptr_pkg::PIXEL_W-1:0] wr_data
);

  logic [ptr_pkg::PIXEL_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/ptr_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptr_engine
// Sequencer for the frame store: clearing pass, span drawing by
// read-modify-write, scan with decay and pixel writes.
// ----------------------------------------------------------------------------
module ptr_engine #(
  parameter int FRAME_WIDTH  = ptr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ptr_pkg::FRAME_HEIGHT_DEF,
  localparam int COL_W  = $clog2(FRAME_WIDTH),
  localparam int ROW_W  = $clog2(FRAME_HEIGHT),
  localparam int ADDR_W = ROW_W + COL_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  op,
  input  wire logic [8:0]                  sample_row,
  input  wire logic                        first_of_trace,
  input  wire logic [1:0]                  channel,
  input  wire logic [9:0]                  pixel_column,
  input  wire logic [8:0]                  pixel_row,
  input  wire logic [ptr_pkg::PIXEL_W-1:0] pixel_word,
  // settings
  input  wire logic [7:0]                  inc_step,
  input  wire logic [7:0]                  dec_step,
  // result side
  input  wire logic                        out_free,
  output ptr_pkg::res_t                    res,
  // frame store
  output logic                             mem_rd_en,
  output logic [ADDR_W-1:0]                mem_rd_addr,
  input  wire logic [ptr_pkg::PIXEL_W-1:0] mem_rd_data,
  output logic                             mem_wr_en,
  output logic [ADDR_W-1:0]                mem_wr_addr,
  output logic [ptr_pkg::PIXEL_W-1:0]      mem_wr_data
);

  localparam int CMP_W = ptr_pkg::CMP_W;

  ptr_pkg::state_t state, state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic [ROW_W-1:0]  prev_row;
  logic [COL_W-1:0]  cur_col;

  // span registers
  logic [ROW_W-1:0]  draw_row;
  logic [ROW_W-1:0]  draw_tgt;
  logic              draw_up;
  logic [1:0]        draw_ch;
  logic [ROW_W-1:0]  draw_step;
  logic              span_done;

  // scan registers
  logic [ADDR_W-1:0] scan_addr;
  logic              scan_inside;

  logic              accept;
  logic [ROW_W-1:0]  row_clamp;
  logic              col_last;
  logic              px_inside;
  logic [ADDR_W-1:0] px_addr;
  logic              do_draw;
  logic              clr_last;

  // input decode
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ptr_pkg::ST_IDLE);
  assign row_clamp = (CMP_W'(sample_row) > CMP_W'(FRAME_HEIGHT - 1))
                     ? ROW_W'(FRAME_HEIGHT - 1) : ROW_W'(sample_row);
  assign col_last  = (cur_col == COL_W'(FRAME_WIDTH - 1));
  assign px_inside = (CMP_W'(pixel_column) < CMP_W'(FRAME_WIDTH)) &&
                     (CMP_W'(pixel_row) < CMP_W'(FRAME_HEIGHT));
  assign px_addr   = {ROW_W'(pixel_row), COL_W'(pixel_column)};
  assign do_draw   = (op == ptr_pkg::OP_TRACE) && !first_of_trace && !col_last &&
                     (channel != ptr_pkg::CH_NONE);
  assign clr_last  = (clr_addr == {ADDR_W{1'b1}});

  // span stepping; the target row itself is drawn only for a flat span
  assign draw_step = draw_up ? (draw_row + ROW_W'(1)) : (draw_row - ROW_W'(1));
  assign span_done = (draw_row == draw_tgt) || (draw_step == draw_tgt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptr_pkg::ST_CLEAR: begin
        if (clr_last) state_next = ptr_pkg::ST_IDLE;
      end
      ptr_pkg::ST_IDLE: begin
        if (accept && do_draw) begin
          state_next = ptr_pkg::ST_DRAW_RD;
        end else if (accept && (op == ptr_pkg::OP_SCAN)) begin
          state_next = ptr_pkg::ST_SCAN_WR;
        end
      end
      ptr_pkg::ST_DRAW_RD: state_next = ptr_pkg::ST_DRAW_WR;
      ptr_pkg::ST_DRAW_WR: begin
        state_next = span_done ? ptr_pkg::ST_IDLE : ptr_pkg::ST_DRAW_RD;
      end
      ptr_pkg::ST_SCAN_WR: begin
        if (out_free) state_next = ptr_pkg::ST_IDLE;
      end
      default: state_next = ptr_pkg::ST_IDLE;
    endcase
  end

  // memory ports and result
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = px_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = px_addr;
    mem_wr_data = pixel_word;
    res.valid   = 1'b0;
    res.pixel   = '0;
    unique case (state)
      ptr_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      ptr_pkg::ST_IDLE: begin
        mem_rd_en = accept && (op == ptr_pkg::OP_SCAN) && px_inside;
        mem_wr_en = accept && (op == ptr_pkg::OP_WRITE) && px_inside;
      end
      ptr_pkg::ST_DRAW_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = {draw_row, cur_col};
      end
      ptr_pkg::ST_DRAW_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = {draw_row, cur_col};
        mem_wr_data = ptr_pkg::hit_pixel(mem_rd_data, draw_ch, inc_step);
      end
      ptr_pkg::ST_SCAN_WR: begin
        mem_wr_en   = out_free && scan_inside;
        mem_wr_addr = scan_addr;
        mem_wr_data = ptr_pkg::decay_pixel(mem_rd_data, dec_step);
        res.valid   = out_free;
        res.pixel   = scan_inside ? ptr_pkg::decay_pixel(mem_rd_data, dec_step) : '0;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptr_pkg::ST_CLEAR;
      clr_addr <= '0;
      prev_row <= '0;
      cur_col  <= '0;
    end else begin
      state <= state_next;
      if (state == ptr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (accept && (op == ptr_pkg::OP_TRACE)) begin
        prev_row <= row_clamp;
        if (first_of_trace) begin
          cur_col <= '0;
        end else if (!col_last && (channel == ptr_pkg::CH_NONE)) begin
          cur_col <= cur_col + COL_W'(1);
        end
      end
      if ((state == ptr_pkg::ST_DRAW_WR) && span_done) begin
        cur_col <= cur_col + COL_W'(1);
      end
    end
  end

  // span and scan payload
  always_ff @(posedge clk) begin
    if (accept && do_draw) begin
      draw_row <= prev_row;
      draw_tgt <= row_clamp;
      draw_up  <= (row_clamp > prev_row);
      draw_ch  <= channel;
    end else if ((state == ptr_pkg::ST_DRAW_WR) && !span_done) begin
      draw_row <= draw_step;
    end
    if (accept && (op == ptr_pkg::OP_SCAN)) begin
      scan_addr   <= px_addr;
      scan_inside <= px_inside;
    end
  end

endmodule
`default_nettype wire

@@ src/phosphor_trace_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phosphor_trace_renderer
// Persistence display frame store: trace samples brighten vertical spans,
// scans return pixels and fade them, writes load pixels.
// ----------------------------------------------------------------------------
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+-----------------
//  items    | op, sample_row, first_of_trace, channel,   | in_valid/in_ready
//           | pixel_column, pixel_row, pixel_word        |
//  results  | pixel_out                                  | out_valid/out_ready
//  settings | cfg_index, cfg_data                        | cfg_we
//
// A trace sample is drawn pixel by pixel: each pixel is a read
// and a write-back through the frame store's single read and write ports.
// First-of-trace, write and undrawn samples end when taken; a scan writes back.
// After reset a clearing pass writes zero to all 2**(ROW_W+COL_W) entries
// (524288 at the default size) while in_ready stays low.
// A scan holds in its write-back cycle while the result register is full.
// ----------------------------------------------------------------------------
module phosphor_trace_renderer #(
  parameter int FRAME_WIDTH  = ptr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = ptr_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [7:0]                  cfg_data,
  // items
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  op,
  input  wire logic [8:0]                  sample_row,
  input  wire logic                        first_of_trace,
  input  wire logic [1:0]                  channel,
  input  wire logic [9:0]                  pixel_column,
  input  wire logic [8:0]                  pixel_row,
  input  wire logic [ptr_pkg::PIXEL_W-1:0] pixel_word,
  // results
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ptr_pkg::PIXEL_W-1:0]      pixel_out
);

  localparam int ADDR_W = $clog2(FRAME_WIDTH) + $clog2(FRAME_HEIGHT);

  logic [7:0] inc_step;
  logic [7:0] dec_step;

  ptr_pkg::res_t res;
  logic          out_free;

  logic                        mem_rd_en;
  logic [ADDR_W-1:0]           mem_rd_addr;
  logic [ptr_pkg::PIXEL_W-1:0] mem_rd_data;
  logic                        mem_wr_en;
  logic [ADDR_W-1:0]           mem_wr_addr;
  logic [ptr_pkg::PIXEL_W-1:0] mem_wr_data;

  // settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inc_step <= '0;
      dec_step <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptr_pkg::CFG_INC_STEP: inc_step <= cfg_data;
        ptr_pkg::CFG_DEC_STEP: dec_step <= cfg_data;
        default:               inc_step <= inc_step;
      endcase
    end
  end

  // result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      pixel_out <= res.pixel;
    end
  end

  ptr_engine #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .sample_row     (sample_row),
    .first_of_trace (first_of_trace),
    .channel        (channel),
    .pixel_column   (pixel_column),
    .pixel_row      (pixel_row),
    .pixel_word     (pixel_word),
    .inc_step       (inc_step),
    .dec_step       (dec_step),
    .out_free       (out_free),
    .res            (res),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data)
  );

  ptr_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule
`default_nettype wire

@@ src/ptr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptr_checker
// Port-level checks for the phosphor trace renderer, bound to the top level.
// ----------------------------------------------------------------------------
module ptr_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [1:0]                  op,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ptr_pkg::PIXEL_W-1:0] pixel_out
);

  // reset drops any pending result
  a_rst_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // clearing pass blocks items after reset
  a_rst_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken during clearing pass");

  // a scan item occupies the block for its write-back cycle
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == ptr_pkg::OP_SCAN)) |=> !in_ready)
    else $error("item taken while a scan is in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)))
    else $error("stalled result changed");

endmodule

bind phosphor_trace_renderer ptr_checker u_ptr_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for phosphor_trace_renderer. A directed table covers
// reset contents, extreme pixels, every operation, span directions,
// saturation and the decay floor. Random phases then send trace bursts,
// scans of recently drawn pixels, writes and stray items under changing
// idle/stall pressure and step settings. One long trace runs the column out
// to the right edge. Every scanned pixel is checked against a frame model or a table value.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAME_W = ptr_pkg::FRAME_WIDTH_DEF;
  localparam int FRAME_H = ptr_pkg::FRAME_HEIGHT_DEF;
  // long enough for the longest span, plus margin
  localparam int SETTLE_CYCLES = 2 * FRAME_H + 64;
  // the edge trace alone is about a thousand items, so the random phases stay short
  localparam int PHASE_ITEMS = 20;
  localparam int HOT_DEPTH = 256;

  typedef struct packed {
    logic [1:0]  op;
    logic [8:0]  sample_row;
    logic        first;
    logic [1:0]  channel;
    logic [9:0]  pixel_column;
    logic [8:0]  pixel_row;
    logic [23:0] pixel_word;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic        typed;
    logic [23:0] pix;
  } dir_row_t;

  // dut ports
  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = ptr_pkg::OP_NONE;
  logic [8:0]  sample_row = '0;
  logic        first_of_trace = 1'b0;
  logic [1:0]  channel = ptr_pkg::CH_BLUE;
  logic [9:0]  pixel_column = '0;
  logic [8:0]  pixel_row = '0;
  logic [23:0] pixel_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] pixel_out;

  // frame model state
  logic [23:0] persist_mem [int];
  int          col_pos = 0;
  int          row_pos = 0;
  logic [7:0]  inc_step = '0;
  logic [7:0]  dec_step = '0;

  logic [23:0] pixels_due [$];
  int          recent_hits [$];
  dir_row_t    dir_rows [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int hits_drawn = 0;

  phosphor_trace_renderer #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .sample_row    (sample_row),
    .first_of_trace(first_of_trace),
    .channel       (channel),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .pixel_word    (pixel_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_out     (pixel_out)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------
  // frame model
  // ------------------------------------------------------------------
  function automatic logic [23:0] pixel_at(int a);
    return persist_mem.exists(a) ? persist_mem[a] : 24'h0;
  endfunction

  function automatic void remember(int a);
    recent_hits.push_back(a);
    if (recent_hits.size() > HOT_DEPTH) void'(recent_hits.pop_front());
  endfunction

  // one hit on one colour byte, saturating
  function automatic void brighten(int r, int c, logic [1:0] ch);
    int          a;
    logic [23:0] px;
    logic [8:0]  s;
    a = r * FRAME_W + c;
    px = pixel_at(a);
    s = {1'b0, px[ch*8 +: 8]} + {1'b0, inc_step};
    px[ch*8 +: 8] = s[8] ? 8'hFF : s[7:0];
    persist_mem[a] = px;
    remember(a);
    hits_drawn++;
  endfunction

  // apply one item to the model; scans yield a pixel
  function automatic void render_item(input item_t it, output logic gives_pix,
                                      output logic [23:0] pix);
    int          target;
    int          r;
    int          a;
    logic        in_frame;
    logic [23:0] px;
    logic [7:0]  g;
    logic [7:0]  rd;
    gives_pix = 1'b0;
    pix = '0;
    in_frame = (int'(it.pixel_column) < FRAME_W) && (int'(it.pixel_row) < FRAME_H);
    a = int'(it.pixel_row) * FRAME_W + int'(it.pixel_column);
    case (it.op)
      ptr_pkg::OP_TRACE: begin
        target = (int'(it.sample_row) > FRAME_H - 1) ? FRAME_H - 1 : int'(it.sample_row);
        if (it.first) begin
          col_pos = 0;
        end else if (col_pos < FRAME_W - 1) begin
          if (it.channel != ptr_pkg::CH_NONE) begin
            r = row_pos;
            if (r == target) brighten(r, col_pos, it.channel);
            // span toward the new row, new row excluded
            while (r != target) begin
              brighten(r, col_pos, it.channel);
              r = (target > r) ? r + 1 : r - 1;
            end
          end
          col_pos++;
        end
        row_pos = target;
      end
      ptr_pkg::OP_SCAN: begin
        gives_pix = 1'b1;
        if (in_frame) begin
          px = pixel_at(a);
          g = (px[15:8] > dec_step) ? px[15:8] - dec_step : 8'd0;
          rd = (px[23:16] > dec_step) ? px[23:16] - dec_step : 8'd0;
          px = {rd, g, px[7:0]};
          persist_mem[a] = px;
          pix = px;
        end
      end
      ptr_pkg::OP_WRITE: begin
        if (in_frame) begin
          persist_mem[a] = it.pixel_word;
          remember(a);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------
  task automatic set_reg(input logic [0:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == ptr_pkg::CFG_INC_STEP) inc_step = val;
    else dec_step = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // present one item, wait for acceptance, update the model
  task automatic send_item(input item_t it, input logic typed, input logic [23:0] typed_pix);
    logic        gives;
    logic [23:0] pix;
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    op <= it.op;
    sample_row <= it.sample_row;
    first_of_trace <= it.first;
    channel <= it.channel;
    pixel_column <= it.pixel_column;
    pixel_row <= it.pixel_row;
    pixel_word <= it.pixel_word;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    render_item(it, gives, pix);
    if (gives) pixels_due.push_back(typed ? typed_pix : pix);
    if (it.op != ptr_pkg::OP_NONE) n_sent++;
  endtask

  task automatic release_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for all pixels, then let any trailing span finish
  task automatic settle();
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result check
  always @(posedge clk) begin : check_pixels
    logic [23:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel_out with no scan pending: got %06h", pixel_out);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        n_checked++;
        if (pixel_out !== want) begin
          $error("pixel_out mismatch: expected %06h, actual %06h", want, pixel_out);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  function automatic item_t scrambled_item();
    item_t it;
    it.op = 2'($urandom_range(3));
    it.sample_row = 9'($urandom);
    it.first = 1'($urandom);
    it.channel = 2'($urandom);
    it.pixel_column = 10'($urandom);
    it.pixel_row = 9'($urandom);
    it.pixel_word = 24'($urandom);
    return it;
  endfunction

  function automatic dir_row_t dir_step(logic [1:0] o, int srow, logic fst, logic [1:0] ch,
                                        int pc, int pr, logic [23:0] word,
                                        logic typed, logic [23:0] pix);
    dir_row_t d;
    d.it.op = o;
    d.it.sample_row = 9'(srow);
    d.it.first = fst;
    d.it.channel = ch;
    d.it.pixel_column = 10'(pc);
    d.it.pixel_row = 9'(pr);
    d.it.pixel_word = word;
    d.typed = typed;
    d.pix = pix;
    return d;
  endfunction

  // mostly small row moves, sometimes a full jump
  function automatic logic [8:0] next_row();
    int r;
    if ($urandom_range(99) < 3) return 9'($urandom);
    r = row_pos + int'($urandom_range(8)) - 4;
    if (r < 0) r = 0;
    if (r > FRAME_H - 1) r = FRAME_H - 1;
    return 9'(r);
  endfunction

  // recently touched pixel most of the time, anywhere otherwise
  task automatic pick_pixel(output logic [9:0] c, output logic [8:0] r);
    int a;
    if (recent_hits.size() != 0 && $urandom_range(3) != 0) begin
      a = recent_hits[$urandom_range(recent_hits.size() - 1)];
      c = 10'(a % FRAME_W);
      r = 9'(a / FRAME_W);
    end else begin
      c = 10'($urandom);
      r = 9'($urandom);
    end
  endtask

  // a trace start followed by n samples; sparse draws mostly on no channel
  task automatic trace_burst(int n, logic sparse);
    item_t it;
    int    k;
    it = scrambled_item();
    it.op = ptr_pkg::OP_TRACE;
    it.first = 1'b1;
    send_item(it, 1'b0, '0);
    for (k = 0; k < n; k++) begin
      it = scrambled_item();
      it.op = ptr_pkg::OP_TRACE;
      it.first = 1'b0;
      it.sample_row = next_row();
      if (sparse)
        it.channel = (col_pos == FRAME_W - 2 || $urandom_range(9) == 0) ?
                     2'($urandom_range(2)) : ptr_pkg::CH_NONE;
      else
        it.channel = ($urandom_range(9) == 0) ? ptr_pkg::CH_NONE : 2'($urandom_range(2));
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic scan_some(int n);
    item_t it;
    repeat (n) begin
      it = scrambled_item();
      it.op = ptr_pkg::OP_SCAN;
      pick_pixel(it.pixel_column, it.pixel_row);
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic random_phase(int goal);
    int    stop;
    int    pick;
    item_t it;
    stop = n_sent + goal;
    while (n_sent < stop) begin
      pick = $urandom_range(99);
      it = scrambled_item();
      if (pick < 45) begin
        trace_burst($urandom_range(1, 12), 1'b0);
      end else if (pick < 75) begin
        scan_some($urandom_range(1, 3));
      end else if (pick < 87) begin
        it.op = ptr_pkg::OP_WRITE;
        pick_pixel(it.pixel_column, it.pixel_row);
        send_item(it, 1'b0, '0);
      end else if (pick < 93) begin
        it.op = ptr_pkg::OP_NONE;
        send_item(it, 1'b0, '0);
      end else begin
        // stray sample outside any fresh trace start
        it.op = ptr_pkg::OP_TRACE;
        it.first = 1'b0;
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin : main
    int k;

    // directed table, steps inc 200 and dec 60
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                0, 0, 0, 1, 24'h000000));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                1023, 511, 0, 1, 24'h000000));
    dir_rows.push_back(dir_step(ptr_pkg::OP_WRITE, 0, 0, ptr_pkg::CH_BLUE,
                                1023, 511, 24'hFFFFFF, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                1023, 511, 0, 1, 24'hC3C3FF));
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 10, 1, ptr_pkg::CH_BLUE,
                                0, 0, 0, 0, 0));
    // equal rows: single pixel
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 10, 0, ptr_pkg::CH_GREEN,
                                0, 0, 0, 0, 0));
    // downward and upward spans
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 13, 0, ptr_pkg::CH_RED,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 11, 0, ptr_pkg::CH_BLUE,
                                0, 0, 0, 0, 0));
    // no channel: column still advances
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 511, 0, ptr_pkg::CH_NONE,
                                0, 0, 0, 0, 0));
    // full-height span
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 0, 0, ptr_pkg::CH_GREEN,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                0, 10, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                1, 12, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                2, 13, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                4, 1, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                4, 0, 0, 0, 0));
    // unused op code, all fields high
    dir_rows.push_back(dir_step(ptr_pkg::OP_NONE, 511, 1, ptr_pkg::CH_NONE,
                                1023, 511, 24'hFFFFFF, 0, 0));
    // two hits on one pixel saturate red
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 20, 1, ptr_pkg::CH_RED,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 20, 0, ptr_pkg::CH_RED,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 20, 1, ptr_pkg::CH_RED,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_TRACE, 20, 0, ptr_pkg::CH_RED,
                                0, 0, 0, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                0, 20, 0, 1, 24'hC30000));
    // decay floors at zero, blue kept
    dir_rows.push_back(dir_step(ptr_pkg::OP_WRITE, 0, 0, ptr_pkg::CH_BLUE,
                                7, 3, 24'h201010, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                7, 3, 0, 1, 24'h000010));
    dir_rows.push_back(dir_step(ptr_pkg::OP_WRITE, 0, 0, ptr_pkg::CH_BLUE,
                                1023, 0, 24'hABCDEF, 0, 0));
    dir_rows.push_back(dir_step(ptr_pkg::OP_SCAN, 0, 0, ptr_pkg::CH_BLUE,
                                1023, 0, 0, 0, 0));

    // reset, then wait out the clearing pass
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    set_reg(ptr_pkg::CFG_INC_STEP, 8'd200);
    set_reg(ptr_pkg::CFG_DEC_STEP, 8'd60);
    for (k = 0; k < dir_rows.size(); k++)
      send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].pix);
    release_valid();
    settle();

    // full brightness, no fade, no idling; long trace to the right edge
    set_reg(ptr_pkg::CFG_INC_STEP, 8'd255);
    set_reg(ptr_pkg::CFG_DEC_STEP, 8'd0);
    trace_burst(FRAME_W + 8, 1'b1);
    scan_some(12);
    random_phase(PHASE_ITEMS);
    release_valid();
    settle();

    // no brightening, full fade, sender idling
    set_reg(ptr_pkg::CFG_INC_STEP, 8'd0);
    set_reg(ptr_pkg::CFG_DEC_STEP, 8'd255);
    idle_pct = 56;
    random_phase(PHASE_ITEMS);
    release_valid();
    settle();

    // random steps, receiver stalling
    set_reg(ptr_pkg::CFG_INC_STEP, 8'($urandom));
    set_reg(ptr_pkg::CFG_DEC_STEP, 8'($urandom));
    idle_pct = 0;
    stall_pct = 56;
    random_phase(PHASE_ITEMS);
    release_valid();
    settle();

    // random steps, both sides idling
    set_reg(ptr_pkg::CFG_INC_STEP, 8'($urandom));
    set_reg(ptr_pkg::CFG_DEC_STEP, 8'($urandom));
    idle_pct = 20;
    stall_pct = 20;
    random_phase(PHASE_ITEMS);
    release_valid();
    settle();

    $display("covered %0d items over 5 phases: %0d pixel hits drawn, %0d scans checked",
             n_sent, hits_drawn, n_checked);
    $display("steps swept from 0 to 255, trace run to the last column, %0d errors", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("timeout with %0d scans outstanding", pixels_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
